### sv/dmwbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dmwbc_pkg;

  localparam int unsigned ADDR_BITS  = 16;
  localparam int unsigned NUM_LINES  = 32;
  localparam int unsigned LINE_BYTES = 8;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef struct packed {
    logic                 command;
    logic [ADDR_BITS-1:0] address;
    logic [7:0]           write_data;
  } in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       hit;
    logic       dirty_flag;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic clear_we;
    logic lookup;
    logic fill;
    logic load_out;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;
    logic is_write;
    logic clear_last;
  } ctrl_sts_t;

endpackage

`default_nettype wire

### sv/dmwbc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module dmwbc_datapath #(
  parameter int unsigned NUM_LINES  = dmwbc_pkg::NUM_LINES,
  parameter int unsigned LINE_BYTES = dmwbc_pkg::LINE_BYTES
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  dmwbc_pkg::in_t         in_i,
  input  dmwbc_pkg::ctrl_cmd_t   cmd_i,
  output dmwbc_pkg::ctrl_sts_t   sts_o,
  output dmwbc_pkg::out_t        out_o
);

  localparam int unsigned ADDR_BITS = dmwbc_pkg::ADDR_BITS;
  localparam int unsigned OFF_W     = $clog2(LINE_BYTES);
  localparam int unsigned IDX_W     = $clog2(NUM_LINES);
  localparam int unsigned TAG_W     = ADDR_BITS - IDX_W - OFF_W;
  localparam int unsigned BLK_W     = ADDR_BITS - OFF_W;
  localparam int unsigned LINE_W    = LINE_BYTES * 8;
  localparam int unsigned NUM_BLKS  = 2 ** BLK_W;

  // request register
  dmwbc_pkg::in_t req_q;

  logic [OFF_W-1:0] off;
  logic [IDX_W-1:0] idx;
  logic [TAG_W-1:0] tag;
  logic [BLK_W-1:0] blk;

  assign off = req_q.address[OFF_W-1:0];
  assign idx = req_q.address[OFF_W+IDX_W-1:OFF_W];
  assign tag = req_q.address[ADDR_BITS-1:OFF_W+IDX_W];
  assign blk = req_q.address[ADDR_BITS-1:OFF_W];

  // line storage
  logic [LINE_W-1:0]    line_mem [NUM_LINES];
  logic [TAG_W-1:0]     tag_mem  [NUM_LINES];
  logic [LINE_W-1:0]    line_rd_q;
  logic [TAG_W-1:0]     tag_rd_q;
  logic [NUM_LINES-1:0] valid_q;
  logic [NUM_LINES-1:0] dirty_q;

  // backing store
  logic [LINE_W-1:0] bs_mem [NUM_BLKS];
  logic [LINE_W-1:0] bs_rd_q;
  logic [BLK_W-1:0]  clr_q;

  logic              hit;
  logic              victim_dirty;
  logic              wb_we;
  logic              bs_we;
  logic [BLK_W-1:0]  bs_waddr;
  logic [LINE_W-1:0] bs_wdata;
  logic              line_we;
  logic [LINE_W-1:0] line_base;
  logic [LINE_W-1:0] line_wdata;

  logic [7:0] rdata_q;
  logic       hit_q;
  logic       dflag_q;
  dmwbc_pkg::out_t out_q;

  assign hit          = valid_q[idx] && (tag_rd_q == tag);
  assign victim_dirty = valid_q[idx] && dirty_q[idx];
  assign wb_we        = cmd_i.lookup && !hit && victim_dirty;

  assign sts_o.hit        = hit;
  assign sts_o.is_write   = (req_q.command == dmwbc_pkg::CMD_WRITE);
  assign sts_o.clear_last = &clr_q;

  always_comb begin
    bs_we    = cmd_i.clear_we || wb_we;
    bs_waddr = cmd_i.clear_we ? clr_q : {tag_rd_q, idx};
    bs_wdata = cmd_i.clear_we ? '0 : line_rd_q;
  end

  // byte merge on the line being written
  always_comb begin
    line_base  = cmd_i.fill ? bs_rd_q : line_rd_q;
    line_wdata = line_base;
    if (req_q.command == dmwbc_pkg::CMD_WRITE) begin
      line_wdata[{off, 3'b000} +: 8] = req_q.write_data;
    end
    line_we = cmd_i.fill
           || (cmd_i.lookup && hit && (req_q.command == dmwbc_pkg::CMD_WRITE));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q <= in_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (line_we) begin
      line_mem[idx] <= line_wdata;
    end
    if (cmd_i.accept) begin
      line_rd_q <= line_mem[in_i.address[OFF_W+IDX_W-1:OFF_W]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fill) begin
      tag_mem[idx] <= tag;
    end
    if (cmd_i.accept) begin
      tag_rd_q <= tag_mem[in_i.address[OFF_W+IDX_W-1:OFF_W]];
    end
  end

  // victim write-back and new block read share the miss cycle
  always_ff @(posedge clk_i) begin
    if (bs_we) begin
      bs_mem[bs_waddr] <= bs_wdata;
    end
    if (cmd_i.lookup) begin
      bs_rd_q <= bs_mem[blk];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      dirty_q <= '0;
      clr_q   <= '0;
    end else begin
      if (cmd_i.clear_we) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.fill) begin
        valid_q[idx] <= 1'b1;
        dirty_q[idx] <= (req_q.command == dmwbc_pkg::CMD_WRITE);
      end else if (line_we) begin
        dirty_q[idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      hit_q   <= hit;
      dflag_q <= hit ? dirty_q[idx] : victim_dirty;
      rdata_q <= line_rd_q[{off, 3'b000} +: 8];
    end else if (cmd_i.fill) begin
      rdata_q <= bs_rd_q[{off, 3'b000} +: 8];
    end
    if (cmd_i.load_out) begin
      out_q.read_data  <= rdata_q;
      out_q.hit        <= hit_q;
      out_q.dirty_flag <= dflag_q;
    end
  end

  assign out_o = out_q;

endmodule

`default_nettype wire

### sv/dmwbc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module dmwbc_ctrl (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  input  dmwbc_pkg::ctrl_sts_t   sts_i,
  output dmwbc_pkg::ctrl_cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_FILL,
    ST_RESP
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_we = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        if (!sts_i.hit) begin
          state_d = ST_FILL;
        end else if (sts_i.is_write) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_FILL: begin
        cmd_o.fill = 1'b1;
        state_d    = sts_i.is_write ? ST_IDLE : ST_RESP;
      end
      ST_RESP: begin
        // wait for the output register to free up
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

### sv/direct_mapped_writeback_cache.sv
// read hit: lookup, then the result stage; read miss: lookup, fill, then the result stage
// write hit: lookup only; write miss: lookup, then fill; writes return no result
// one request at a time: lookup, then on a miss write-back and block read in the same backing cycle, fill
// a finished result waits in the output register while the next request is taken
// reset: async active low; the backing store is then zeroed one block a cycle,
// all 2**(ADDR_BITS - log2(LINE_BYTES)) blocks (8192 by default) before the first request is taken
`timescale 1ns / 1ps
`default_nettype none

module direct_mapped_writeback_cache #(
  parameter int unsigned NUM_LINES  = dmwbc_pkg::NUM_LINES,
  parameter int unsigned LINE_BYTES = dmwbc_pkg::LINE_BYTES
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  dmwbc_pkg::in_t    in_i,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output dmwbc_pkg::out_t   out_o
);

  dmwbc_pkg::ctrl_cmd_t cmd;
  dmwbc_pkg::ctrl_sts_t sts;

  dmwbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dmwbc_datapath #(
    .NUM_LINES  (NUM_LINES),
    .LINE_BYTES (LINE_BYTES)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire

### sv/dmwbc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module dmwbc_checker (
  input wire             clk_i,
  input wire             rst_ni,
  input wire             in_valid_i,
  input wire             in_ready_o,
  input dmwbc_pkg::in_t  in_i,
  input wire             out_valid_o,
  input wire             out_ready_i,
  input dmwbc_pkg::out_t out_o
);

  // a waiting result holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("result changed while stalled");

  // a stalled request holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_i))
    else $error("request changed while stalled");

  // one request at a time: busy right after taking one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while busy");

  // a result only appears after the block was busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result without prior work");

endmodule

bind direct_mapped_writeback_cache dmwbc_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_i        (in_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_o       (out_o)
);

`default_nettype wire
